// ----- sv/ddr3_spd_checker_decoder_core_assert.svh -----
// Assertion macros shared by the SPD checker modules.
`ifndef DDR3_SPD_CHECKER_DECODER_CORE_ASSERT_SVH
`define DDR3_SPD_CHECKER_DECODER_CORE_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define DDR3SPD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ddr3spd assertion failed");

// Clocked assertion that also holds during reset.
`define DDR3SPD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ddr3spd assertion failed");

`endif

// ----- sv/ddr3spd_pkg.sv -----
// Types, constants and CRC function of the SPD checker.
package ddr3spd_pkg;

  localparam logic [8:0]  RecordBytes = 9'd256;
  localparam int          HdrBytes    = 9;
  localparam logic [15:0] CrcPoly     = 16'h1021;
  localparam logic [7:0]  CovShort    = 8'd117;
  localparam logic [7:0]  CovLong     = 8'd126;
  localparam logic [7:0]  PosMirror   = 8'd63;
  localparam logic [7:0]  PosCrcLo    = 8'd126;
  localparam logic [7:0]  PosCrcHi    = 8'd127;
  localparam logic [7:0]  DramDdr3    = 8'h0b;
  localparam int          QueueDepth  = 2;
  localparam int          QueueAw     = 1;

  typedef enum logic [3:0] {
    StOk       = 4'd0,
    StSizeInfo = 4'd1,
    StCrc      = 4'd2,
    StNotDdr3  = 4'd3,
    StModType  = 4'd4,
    StDensity  = 4'd5,
    StAddr     = 4'd6,
    StOrg      = 4'd7,
    StBusWidth = 4'd8
  } status_e;

  // Snapshot of one record handed from front to back.
  typedef struct packed {
    logic [15:0]                 crc;
    logic [7:0]                  count;
    logic [HdrBytes-1:0][7:0]    hdr;
    logic                        mirror;
    logic [15:0]                 stored_crc;
  } rec_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] computed_crc;
    logic [15:0] stored_crc;
    logic [3:0]  mod_type;
    logic [2:0]  bank_bits;
    logic [4:0]  row_bits;
    logic [3:0]  col_bits;
    logic [3:0]  rank_count;
    logic [5:0]  device_width;
    logic [6:0]  bus_width;
    logic [18:0] capacity_mib;
    logic [4:0]  flag_bits;
  } res_t;

  // CRC-16, MSB first, one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] coverage(input logic [7:0] b0);
    return b0[7] ? CovShort : CovLong;
  endfunction

endpackage

// ----- sv/ddr3spd_front.sv -----
// Byte front end: CRC, header capture and record snapshot.
module ddr3spd_front import ddr3spd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       record_end_i,
  input  logic       q_full_i,
  output logic       push_o,
  output rec_t       push_rec_o
);

  logic [7:0]               cnt_q, cnt_d;
  logic [15:0]              crc_q, crc_d;
  logic [HdrBytes-1:0][7:0] hdr_q, hdr_d;
  logic                     mir_q, mir_d;
  logic [15:0]              scrc_q, scrc_d;
  logic                     accept;
  logic                     in_range;
  logic [7:0]               b0_eff;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign in_range   = {1'b0, cnt_q} < RecordBytes;
  assign b0_eff     = (cnt_q == 8'd0) ? data_byte_i : hdr_q[0];

  always_comb begin
    cnt_d  = (cnt_q != 8'hff) ? cnt_q + 8'd1 : cnt_q;
    crc_d  = crc_q;
    hdr_d  = hdr_q;
    mir_d  = mir_q;
    scrc_d = scrc_q;
    if (in_range) begin
      if (cnt_q < 8'(HdrBytes)) hdr_d[cnt_q[3:0]] = data_byte_i;
      if (cnt_q < coverage(b0_eff)) crc_d = crc_byte(crc_q, data_byte_i);
      if (cnt_q == PosMirror) mir_d = data_byte_i[0];
      if (cnt_q == PosCrcLo) scrc_d[7:0] = data_byte_i;
      if (cnt_q == PosCrcHi) scrc_d[15:8] = data_byte_i;
    end
  end

  assign push_o                = accept && record_end_i;
  assign push_rec_o.crc        = crc_d;
  assign push_rec_o.count      = cnt_d;
  assign push_rec_o.hdr        = hdr_d;
  assign push_rec_o.mirror     = mir_d;
  assign push_rec_o.stored_crc = scrc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      crc_q  <= '0;
      hdr_q  <= '0;
      mir_q  <= 1'b0;
      scrc_q <= '0;
    end else if (accept) begin
      if (record_end_i) begin
        cnt_q  <= '0;
        crc_q  <= '0;
        hdr_q  <= '0;
        mir_q  <= 1'b0;
        scrc_q <= '0;
      end else begin
        cnt_q  <= cnt_d;
        crc_q  <= crc_d;
        hdr_q  <= hdr_d;
        mir_q  <= mir_d;
        scrc_q <= scrc_d;
      end
    end
  end

endmodule

// ----- sv/ddr3spd_queue.sv -----
// Two-entry record queue between front and back.
module ddr3spd_queue import ddr3spd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t push_rec_i,
  input  logic pop_i,
  output rec_t pop_rec_o,
  output logic full_o,
  output logic empty_o
);

`include "ddr3_spd_checker_decoder_core_assert.svh"

  rec_t                 mem_q [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]     cnt_q;

  assign full_o    = cnt_q == (QueueAw + 1)'(QueueDepth);
  assign empty_o   = cnt_q == '0;
  assign pop_rec_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  `DDR3SPD_ASSERT(a_no_overflow, clk_i, rst_ni, push_i |-> !full_o)
  `DDR3SPD_ASSERT(a_no_underflow, clk_i, rst_ni, pop_i |-> !empty_o)
  `DDR3SPD_ASSERT_ALWAYS(a_cnt_bound, clk_i, !rst_ni || cnt_q <= (QueueAw + 1)'(QueueDepth))

endmodule

// ----- sv/ddr3spd_back.sv -----
// Back end: CRC padding, record checks and result register.
module ddr3spd_back import ddr3spd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  rec_t q_rec_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t res_o
);

`include "ddr3_spd_checker_decoder_core_assert.svh"

  typedef enum logic [2:0] {
    SIdle = 3'b001,
    SPad  = 3'b010,
    SOut  = 3'b100
  } state_e;

  state_e      state_q, state_d;
  rec_t        rec_q;
  logic        out_valid_q;
  res_t        res_q, res_d;
  logic        pad_more;
  logic        load_out;

  logic [7:0]  h0, h2, h3, h4, h5, h6, h7, h8;
  logic [3:0]  mt, g4;
  logic [2:0]  f4, f5, g5, f7, g7, g8;
  logic [1:0]  f8;
  logic [3:0]  ranks;
  logic [4:0]  shamt;
  logic [18:0] cap_base;
  logic [22:0] cap_prod;
  logic        mirror_type;

  assign pad_more = rec_q.count < coverage(rec_q.hdr[0]);
  assign load_out = (state_q == SOut) && (!out_valid_q || !out_stall_i);
  assign pop_o    = (state_q == SIdle) && !q_empty_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (!q_empty_i) state_d = SPad;
      SPad:  if (!pad_more) state_d = SOut;
      SOut:  if (load_out) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= q_rec_i;
    end else if (state_q == SPad && pad_more) begin
      rec_q.crc   <= crc_byte(rec_q.crc, 8'h00);
      rec_q.count <= rec_q.count + 8'd1;
    end
    if (load_out) res_q <= res_d;
  end

  assign h0 = rec_q.hdr[0];
  assign h2 = rec_q.hdr[2];
  assign h3 = rec_q.hdr[3];
  assign h4 = rec_q.hdr[4];
  assign h5 = rec_q.hdr[5];
  assign h6 = rec_q.hdr[6];
  assign h7 = rec_q.hdr[7];
  assign h8 = rec_q.hdr[8];

  assign mt = h3[3:0];
  assign f4 = h4[6:4];
  assign g4 = h4[3:0];
  assign f5 = h5[5:3];
  assign g5 = h5[2:0];
  assign f7 = h7[5:3];
  assign g7 = h7[2:0];
  assign f8 = h8[4:3];
  assign g8 = h8[2:0];

  assign ranks = (f7 == 3'd4) ? 4'd8 : {1'b0, f7} + 4'd1;

  assign mirror_type = (mt == 4'd2) || (mt == 4'd3) || (mt == 4'd4) || (mt == 4'd6) ||
                       (mt == 4'd8) || (mt == 4'd12) || (mt == 4'd13);

  // density/8 * bus / device is a power of two: 2^(6 + g4 + g8 - g7)
  assign shamt    = 5'd6 + {1'b0, g4} + {3'b000, g8[1:0]} - {3'b000, g7[1:0]};
  assign cap_base = 19'd1 << shamt;
  assign cap_prod = {4'b0000, cap_base} * {19'd0, ranks};

  always_comb begin
    res_d = '0;
    res_d.status = StOk;
    if (h0[6:4] != 3'd1 || h0[3:0] < 4'd1 || h0[3:0] > 4'd3) begin
      res_d.status = StSizeInfo;
    end else begin
      res_d.computed_crc = rec_q.crc;
      res_d.stored_crc   = rec_q.stored_crc;
      if (rec_q.crc != rec_q.stored_crc) begin
        res_d.status = StCrc;
      end else if (h2 != DramDdr3) begin
        res_d.status = StNotDdr3;
      end else if (mt < 4'd1 || mt > 4'd13) begin
        res_d.status = StModType;
      end else begin
        res_d.mod_type = mt;
        if (f4 > 3'd3 || g4 > 4'd6) begin
          res_d.status = StDensity;
        end else begin
          res_d.bank_bits = f4 + 3'd3;
          if (f5 > 3'd4 || g5 > 3'd3) begin
            res_d.status = StAddr;
          end else begin
            res_d.row_bits  = {2'b00, f5} + 5'd12;
            res_d.col_bits  = {1'b0, g5} + 4'd9;
            res_d.flag_bits = {2'b00, h6[2:0]};
            if (f7 > 3'd4 || g7 > 3'd3) begin
              res_d.status = StOrg;
            end else begin
              res_d.rank_count   = ranks;
              res_d.device_width = 6'd4 << g7;
              if (f8 > 2'd1 || g8 > 3'd3) begin
                res_d.status = StBusWidth;
              end else begin
                res_d.bus_width    = 7'd8 << g8;
                res_d.capacity_mib = cap_prod[18:0];
                res_d.flag_bits    = {rec_q.mirror & mirror_type, f8[0], h6[2:0]};
              end
            end
          end
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  `DDR3SPD_ASSERT(a_pop_idle, clk_i, rst_ni, pop_o |-> state_q == SIdle)
  `DDR3SPD_ASSERT(a_pad_done, clk_i, rst_ni,
    state_q == SOut |-> rec_q.count >= coverage(rec_q.hdr[0]))
  `DDR3SPD_ASSERT(a_valid_from_out, clk_i, rst_ni,
    $rose(out_valid_q) |-> $past(state_q == SOut))

endmodule

// ----- sv/ddr3_spd_checker_decoder_core.sv -----
// DDR3 SPD record checker and decoder, top level.
// Input channel: one SPD byte per word (data_byte_i, record_end_i), in
// address order from 0; record_end_i marks the record's last byte.
// Output channel: one result word per record with status, CRCs, decoded
// geometry, capacity in MiB and flags.
// Bytes are taken one per cycle. The front end stalls only when the
// two-entry record queue is full.
// Padding: for a short record the back end adds one zero byte to the
// CRC per cycle for each covered byte missing (117 or 126 minus the
// bytes received, at least 0) before the result is registered. A
// back-to-back stream of records of full length runs at one byte per
// cycle while the output does not stall.
// Reset clears the partial record, the queue and the output valid flag.
// A stalled result holds; the back end then waits, the queue fills, and
// the input channel stalls once both entries are taken.
module ddr3_spd_checker_decoder_core import ddr3spd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        record_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [15:0] computed_crc_o,
  output logic [15:0] stored_crc_o,
  output logic [3:0]  mod_type_o,
  output logic [2:0]  bank_bits_o,
  output logic [4:0]  row_bits_o,
  output logic [3:0]  col_bits_o,
  output logic [3:0]  rank_count_o,
  output logic [5:0]  device_width_o,
  output logic [6:0]  bus_width_o,
  output logic [18:0] capacity_mib_o,
  output logic [4:0]  flag_bits_o
);

  logic push, pop, q_full, q_empty;
  rec_t push_rec, pop_rec;
  res_t res;

  ddr3spd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .record_end_i (record_end_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_rec_o   (push_rec)
  );

  ddr3spd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .pop_rec_o  (pop_rec),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  ddr3spd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_rec_i     (pop_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign status_o       = res.status;
  assign computed_crc_o = res.computed_crc;
  assign stored_crc_o   = res.stored_crc;
  assign mod_type_o     = res.mod_type;
  assign bank_bits_o    = res.bank_bits;
  assign row_bits_o     = res.row_bits;
  assign col_bits_o     = res.col_bits;
  assign rank_count_o   = res.rank_count;
  assign device_width_o = res.device_width;
  assign bus_width_o    = res.bus_width;
  assign capacity_mib_o = res.capacity_mib;
  assign flag_bits_o    = res.flag_bits;

endmodule
